// ===== hw/rtl/mdb_pkg.sv =====
// shared constants, types and elaboration-time helpers for the magnitude to level byte pipeline
// no dependencies; used by every module under hw/rtl

package mdb_pkg;

    localparam int FRAC_BITS = 24;
    localparam int MAG_W     = 25;
    localparam int SUM_W     = MAG_W + 1;
    localparam int MSB_W     = $clog2(SUM_W);
    localparam int SHIFT_W   = 6;
    localparam int Y_W       = 63;
    localparam int LOG_FRAC  = 48;
    localparam int STEPS     = LOG_FRAC;
    localparam int LEVEL_W   = 8;
    localparam int D_W       = $clog2(FRAC_BITS + 1) + LOG_FRAC;
    localparam int M_W       = D_W + LEVEL_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = '0;

    localparam logic [63:0] UNITY_INT = 64'd1 << FRAC_BITS;
    localparam logic [63:0] EPS_WIDE  = (UNITY_INT + 64'd500000) / 64'd1000000;
    localparam logic [SUM_W-1:0] EPS  = EPS_WIDE[SUM_W-1:0];

    // (a*a) >> 62, evaluated at elaboration
    function automatic logic [63:0] sq62(input logic [63:0] a);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, a};
        return p[125:62];
    endfunction

    // log2 in unsigned Q48, evaluated at elaboration
    function automatic logic [63:0] log2_q48(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] msb;
        msb  = 64'd0;
        frac = 64'd0;
        for (int i = 1; i < 64; i++)
        begin
            if ((x >> i) != 64'd0)
            begin
                msb = 64'(i);
            end
        end
        y = x << (64'd62 - msb);
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            y    = sq62(y);
            frac = {frac[62:0], y[63]};
            if (y[63])
            begin
                y = y >> 1;
            end
        end
        return (msb << LOG_FRAC) | frac;
    endfunction

    localparam logic [63:0] LOG2_TEN = log2_q48(64'd10);
    localparam logic [63:0] TOP      = 64'd1022 * LOG2_TEN;
    localparam logic [63:0] DIVISOR  = 64'd4 * LOG2_TEN;
    localparam int          NUM_W    = $clog2(TOP + 64'd1);

    typedef struct packed {
        logic                sat;
        logic                zero;
        logic [MSB_W-1:0]    msb;
        logic [LOG_FRAC-1:0] frac;
        logic [Y_W-1:0]      y;
    } mdb_log_t;

    typedef struct packed {
        logic                sat;
        logic                zero;
        logic [MSB_W-1:0]    msb;
        logic [LOG_FRAC-1:0] frac;
        logic [63:0]         p00;
        logic [62:0]         p01;
        logic [61:0]         p11;
    } mdb_prod_t;

    typedef struct packed {
        logic               sat;
        logic               low;
        logic [NUM_W-1:0]   rem;
        logic [LEVEL_W-1:0] q;
    } mdb_div_t;

endpackage

// ===== hw/rtl/mdb_front.sv =====
// front end: input register, epsilon add, leading-one search and normalizing shift
// depends on mdb_pkg

module mdb_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [mdb_pkg::MAG_W-1:0]         magnitude,
    output logic                              out_valid,
    output mdb_pkg::mdb_log_t                 out_tok
);

    logic                          mag_valid_reg;
    logic [mdb_pkg::MAG_W-1:0]     mag_reg;
    logic                          sum_valid_reg;
    logic [mdb_pkg::SUM_W-1:0]     sum_reg;
    logic [mdb_pkg::SUM_W-1:0]     sum_next;
    logic                          tok_valid_reg;
    mdb_pkg::mdb_log_t             tok_reg;
    mdb_pkg::mdb_log_t             tok_next;
    logic [mdb_pkg::MSB_W-1:0]     msb;
    logic [mdb_pkg::SHIFT_W-1:0]   shift;

    assign sum_next = mdb_pkg::SUM_W'(mag_reg) + mdb_pkg::EPS;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < mdb_pkg::SUM_W; i++)
        begin
            if (sum_reg[i])
            begin
                msb = mdb_pkg::MSB_W'(i);
            end
        end
        shift         = mdb_pkg::SHIFT_W'(mdb_pkg::Y_W - 1) - mdb_pkg::SHIFT_W'(msb);
        tok_next.sat  = 64'(sum_reg) >= mdb_pkg::UNITY_INT;
        tok_next.zero = (sum_reg == '0);
        tok_next.msb  = msb;
        tok_next.frac = '0;
        tok_next.y    = mdb_pkg::Y_W'(sum_reg) << shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            mag_valid_reg <= in_valid;
            sum_valid_reg <= mag_valid_reg;
            tok_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= magnitude;
        sum_reg <= sum_next;
        tok_reg <= tok_next;
    end

    assign out_valid = tok_valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== hw/rtl/mdb_log_step.sv =====
// one log2 digit: square the Q62 mantissa from three partial products of its 32-bit and 31-bit halves, then take a bit
// depends on mdb_pkg

module mdb_log_step
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mdb_pkg::mdb_log_t in_tok,
    output logic              out_valid,
    output mdb_pkg::mdb_log_t out_tok
);

    logic                  prod_valid_reg;
    mdb_pkg::mdb_prod_t    prod_reg;
    mdb_pkg::mdb_prod_t    prod_next;
    logic                  tok_valid_reg;
    mdb_pkg::mdb_log_t     tok_reg;
    mdb_pkg::mdb_log_t     tok_next;
    logic [31:0]           a0;
    logic [30:0]           a1;
    logic [33:0]           mid;
    logic [63:0]           hi;
    logic [63:0]           sq;

    // partial products
    always_comb
    begin
        a0             = in_tok.y[31:0];
        a1             = in_tok.y[62:32];
        prod_next.sat  = in_tok.sat;
        prod_next.zero = in_tok.zero;
        prod_next.msb  = in_tok.msb;
        prod_next.frac = in_tok.frac;
        prod_next.p00  = 64'(a0) * 64'(a0);
        prod_next.p01  = 63'(a0) * 63'(a1);
        prod_next.p11  = 62'(a1) * 62'(a1);
    end

    // recombine, shift down by 62, extract the digit
    always_comb
    begin
        mid = 34'(prod_reg.p00[63:32]) + 34'(prod_reg.p01[31:0])
            + 34'(prod_reg.p01[31:0]);
        hi  = 64'(prod_reg.p11) + 64'({prod_reg.p01[62:32], 1'b0}) + 64'(mid[33:32]);
        sq  = {hi[61:0], mid[31:30]};
        tok_next.sat  = prod_reg.sat;
        tok_next.zero = prod_reg.zero;
        tok_next.msb  = prod_reg.msb;
        tok_next.frac = {prod_reg.frac[mdb_pkg::LOG_FRAC-2:0], sq[63]};
        tok_next.y    = sq[63] ? sq[63:1] : sq[62:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            tok_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            tok_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        tok_reg  <= tok_next;
    end

    assign out_valid = tok_valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== hw/rtl/mdb_scale.sv =====
// scaling: distance below unity in Q48, times 255, compared against 1022*log2(10)
// depends on mdb_pkg

module mdb_scale
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mdb_pkg::mdb_log_t in_tok,
    output logic              out_valid,
    output mdb_pkg::mdb_div_t out_tok
);

    logic                      d_valid_reg;
    logic                      d_sat_reg;
    logic                      d_zero_reg;
    logic [mdb_pkg::D_W-1:0]   d_reg;
    logic [mdb_pkg::D_W-1:0]   d_next;
    logic                      m_valid_reg;
    logic                      m_sat_reg;
    logic                      m_zero_reg;
    logic [mdb_pkg::M_W-1:0]   m_reg;
    logic [mdb_pkg::M_W-1:0]   m_next;
    logic                      tok_valid_reg;
    mdb_pkg::mdb_div_t         tok_reg;
    mdb_pkg::mdb_div_t         tok_next;

    assign d_next = ((mdb_pkg::D_W'(mdb_pkg::FRAC_BITS) - mdb_pkg::D_W'(in_tok.msb))
                    << mdb_pkg::LOG_FRAC) - mdb_pkg::D_W'(in_tok.frac);

    assign m_next = (mdb_pkg::M_W'(d_reg) << mdb_pkg::LEVEL_W) - mdb_pkg::M_W'(d_reg);

    always_comb
    begin
        tok_next.sat = m_sat_reg;
        tok_next.low = m_zero_reg | (64'(m_reg) >= mdb_pkg::TOP);
        tok_next.rem = mdb_pkg::NUM_W'(mdb_pkg::TOP - 64'(m_reg));
        tok_next.q   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg   <= in_valid;
            m_valid_reg   <= d_valid_reg;
            tok_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_sat_reg  <= in_tok.sat;
        d_zero_reg <= in_tok.zero;
        d_reg      <= d_next;
        m_sat_reg  <= d_sat_reg;
        m_zero_reg <= d_zero_reg;
        m_reg      <= m_next;
        tok_reg    <= tok_next;
    end

    assign out_valid = tok_valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== hw/rtl/mdb_divide.sv =====
// restoring division by the constant 4*log2(10), one quotient bit per stage
// depends on mdb_pkg

module mdb_divide
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mdb_pkg::mdb_div_t in_tok,
    output logic              out_valid,
    output mdb_pkg::mdb_div_t out_tok
);

    logic              valid_reg [mdb_pkg::LEVEL_W];
    mdb_pkg::mdb_div_t tok_reg   [mdb_pkg::LEVEL_W];
    logic              valid_in  [mdb_pkg::LEVEL_W];
    mdb_pkg::mdb_div_t tok_in    [mdb_pkg::LEVEL_W];
    mdb_pkg::mdb_div_t tok_next  [mdb_pkg::LEVEL_W];

    assign valid_in[0] = in_valid;
    assign tok_in[0]   = in_tok;

    for (genvar j = 0; j < mdb_pkg::LEVEL_W; j++)
    begin : g_stage
        localparam logic [63:0] DIV_SHIFTED = mdb_pkg::DIVISOR << (mdb_pkg::LEVEL_W - 1 - j);

        if (j > 0)
        begin : g_link
            assign valid_in[j] = valid_reg[j-1];
            assign tok_in[j]   = tok_reg[j-1];
        end

        always_comb
        begin
            tok_next[j] = tok_in[j];
            if (64'(tok_in[j].rem) >= DIV_SHIFTED)
            begin
                tok_next[j].rem = mdb_pkg::NUM_W'(64'(tok_in[j].rem) - DIV_SHIFTED);
                tok_next[j].q   = {tok_in[j].q[mdb_pkg::LEVEL_W-2:0], 1'b1};
            end
            else
            begin
                tok_next[j].q   = {tok_in[j].q[mdb_pkg::LEVEL_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            tok_reg[j] <= tok_next[j];
        end
    end

    assign out_valid = valid_reg[mdb_pkg::LEVEL_W-1];
    assign out_tok   = tok_reg[mdb_pkg::LEVEL_W-1];

endmodule

// ===== hw/rtl/magnitude_to_db_byte.sv =====
// top level: converts a linear Q1.24 magnitude to a 0..255 level byte over -80..0 dB
// depends on mdb_pkg, mdb_front, mdb_log_step, mdb_scale, mdb_divide
//
// Fully pipelined: busy is always low, so one magnitude can be transferred on every clock, and
// each one yields exactly one level byte, marked by done for a single cycle. After the front end,
// each magnitude passes through the 48 log2 digit steps, each a 63-bit squaring split into a
// partial-product stage and a recombine stage, then a three-stage scaling section and an
// eight-stage constant division, and the level byte is registered. Results leave in input order
// and the receiver must take them in the cycle that done is high.

module magnitude_to_db_byte
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mdb_pkg::MAG_W-1:0]           magnitude,
    output logic                                done,
    output logic [mdb_pkg::LEVEL_W-1:0]         level_byte
);

    logic                        front_valid;
    mdb_pkg::mdb_log_t           front_tok;
    logic                        step_valid [mdb_pkg::STEPS+1];
    mdb_pkg::mdb_log_t           step_tok   [mdb_pkg::STEPS+1];
    logic                        scale_valid;
    mdb_pkg::mdb_div_t           scale_tok;
    logic                        div_valid;
    mdb_pkg::mdb_div_t           div_tok;
    logic                        done_reg;
    logic [mdb_pkg::LEVEL_W-1:0] level_reg;
    logic [mdb_pkg::LEVEL_W-1:0] level_next;

    assign busy = 1'b0;

    mdb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .magnitude (magnitude),
        .out_valid (front_valid),
        .out_tok   (front_tok)
    );

    assign step_valid[0] = front_valid;
    assign step_tok[0]   = front_tok;

    for (genvar i = 0; i < mdb_pkg::STEPS; i++)
    begin : g_log
        mdb_log_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_valid[i]),
            .in_tok    (step_tok[i]),
            .out_valid (step_valid[i+1]),
            .out_tok   (step_tok[i+1])
        );
    end

    mdb_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_valid[mdb_pkg::STEPS]),
        .in_tok    (step_tok[mdb_pkg::STEPS]),
        .out_valid (scale_valid),
        .out_tok   (scale_tok)
    );

    mdb_divide u_divide
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_tok    (scale_tok),
        .out_valid (div_valid),
        .out_tok   (div_tok)
    );

    always_comb
    begin
        priority if (div_tok.sat)
        begin
            level_next = mdb_pkg::LEVEL_MAX;
        end
        else if (div_tok.low)
        begin
            level_next = mdb_pkg::LEVEL_MIN;
        end
        else
        begin
            level_next = div_tok.q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    assign done       = done_reg;
    assign level_byte = level_reg;

endmodule
